[hw/rtl/wsse_pkg.sv]
// wsse_pkg: shared constants, codes and controller/datapath interface types
// for the weighted sign skew estimator. No dependencies.
`timescale 1ns / 1ps

package wsse_pkg;

    localparam int NUM_STRANDS = 2;
    localparam int STRAND_W    = 1;

    localparam int KIND_W   = 2;
    localparam int RESP_W   = 17;
    localparam int PRIOR_W  = 24;
    localparam int SUM_W    = 32;
    localparam int EST_W    = 24;
    localparam int QUO_W    = 2 * SUM_W;

    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = QUO_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCUM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    localparam logic [RESP_W-1:0]  RESP_ONE = 17'd65536;
    localparam logic [EST_W-1:0]   EST_ONE  = 24'd65536;
    localparam logic [EST_W-1:0]   EST_MAX  = 24'hFFFFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX  = 32'hFFFFFFFF;
    localparam logic [PRIOR_W-1:0] PRIOR_RESET = 24'd65536;

    typedef logic [STRAND_W-1:0] strand_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SQLD,
        ST_SQRT,
        ST_WRITE,
        ST_DONE
    } wsse_state_t;

    typedef struct packed {
        logic    item_apply;
        logic    div_load;
        logic    div_step;
        logic    sqrt_load;
        logic    sqrt_step;
        logic    est_write;
        logic    load_upd_result;
        strand_t strand;
    } wsse_cmd_t;

    typedef struct packed {
        logic down_zero;
    } wsse_status_t;

endpackage

[hw/rtl/wsse_ctrl.sv]
// wsse_ctrl: sequencer for the skew estimator; handshakes and the update
// loop over strands (divide then root). Depends on wsse_pkg.
`timescale 1ns / 1ps

module wsse_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wsse_pkg::KIND_W-1:0]   s_kind,
    output logic                          m_valid,
    input  logic                          m_ready,
    output wsse_pkg::wsse_cmd_t           cmd,
    input  wsse_pkg::wsse_status_t        status
);
    import wsse_pkg::*;

    wsse_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    strand_t           strand_reg, strand_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        strand_next = strand_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_kind == KIND_UPDATE) begin
                    state_next  = ST_LOAD;
                    strand_next = '0;
                end
            end
            ST_LOAD: begin
                cnt_next   = '0;
                state_next = status.down_zero ? ST_WRITE : ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQLD;
                end
            end
            ST_SQLD: begin
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (strand_reg == STRAND_W'(NUM_STRANDS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    strand_next = strand_reg + 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        cmd.strand = strand_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = out_free;
                cmd.item_apply = accept;
            end
            ST_LOAD:  cmd.div_load        = 1'b1;
            ST_DIV:   cmd.div_step        = 1'b1;
            ST_SQLD:  cmd.sqrt_load       = 1'b1;
            ST_SQRT:  cmd.sqrt_step       = 1'b1;
            ST_WRITE: cmd.est_write       = 1'b1;
            ST_DONE:  cmd.load_upd_result = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if ((cmd.item_apply && s_kind != KIND_UPDATE) || cmd.load_upd_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            strand_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            strand_reg  <= strand_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hw/rtl/wsse_datapath.sv]
// wsse_datapath: per-strand sums and estimates, prior register, restoring
// divider, bit-pair square root and result register. Depends on wsse_pkg.
`timescale 1ns / 1ps

module wsse_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [wsse_pkg::PRIOR_W-1:0]  cfg_prior,
    input  logic [wsse_pkg::KIND_W-1:0]   s_kind,
    input  wsse_pkg::strand_t             s_strand_key,
    input  logic [wsse_pkg::RESP_W-1:0]   s_responsibility,
    input  logic                          s_residual_positive,
    input  logic                          s_outlier_hypothesis,
    input  wsse_pkg::wsse_cmd_t           cmd,
    output wsse_pkg::wsse_status_t        status,
    output logic [wsse_pkg::EST_W-1:0]    m_skew_est,
    output logic                          m_saturated
);
    import wsse_pkg::*;

    logic [PRIOR_W-1:0] prior_reg;
    logic [SUM_W-1:0]   up_sum_reg   [NUM_STRANDS];
    logic [SUM_W-1:0]   down_sum_reg [NUM_STRANDS];
    logic [EST_W-1:0]   est_reg      [NUM_STRANDS];
    logic               clip_reg     [NUM_STRANDS];

    strand_t            key_reg;
    logic               key_ok_reg;
    logic               dz_reg;
    logic [QUO_W-1:0]   dvd_reg, dvd_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   dsr_reg;
    logic [QUO_W-1:0]   v_reg, v_next;
    logic [QUO_W-1:0]   r_reg, r_next;
    logic [QUO_W-1:0]   bit_reg;
    logic [EST_W-1:0]   out_est_reg;
    logic               out_sat_reg;

    strand_t            rd_idx;
    logic [SUM_W-1:0]   rd_up, rd_down;
    logic               in_ok;
    logic [RESP_W-1:0]  resp_c;
    logic [SUM_W:0]     acc_sum;
    logic [SUM_W-1:0]   acc_sat;
    logic [SUM_W:0]     rem_sh;
    logic               q_bit;
    logic [QUO_W-1:0]   trial;
    logic               root_clip;
    logic [SUM_W-1:0]   seed;

    assign rd_idx  = cmd.item_apply ? s_strand_key : cmd.strand;
    assign rd_up   = up_sum_reg[rd_idx];
    assign rd_down = down_sum_reg[rd_idx];
    assign status.down_zero = (rd_down == '0);

    assign in_ok   = (int'(s_strand_key) < NUM_STRANDS);
    assign resp_c  = (s_responsibility > RESP_ONE) ? RESP_ONE : s_responsibility;
    assign acc_sum = {1'b0, (s_residual_positive ? rd_up : rd_down)}
                   + (SUM_W + 1)'(resp_c);
    assign acc_sat = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    assign seed    = SUM_W'(prior_reg >> 1);

    // restoring divide, one quotient bit per step
    assign rem_sh   = {rem_reg, dvd_reg[QUO_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, dsr_reg});
    assign rem_next = q_bit ? SUM_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[SUM_W-1:0];
    assign dvd_next = {dvd_reg[QUO_W-2:0], q_bit};

    // square root, one result bit per step
    assign trial  = r_reg + bit_reg;
    assign v_next = (v_reg >= trial) ? v_reg - trial : v_reg;
    assign r_next = (v_reg >= trial) ? (r_reg >> 1) + bit_reg : r_reg >> 1;

    assign root_clip = dz_reg || (r_reg[QUO_W-1:EST_W] != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_reg <= PRIOR_RESET;
            for (int s = 0; s < NUM_STRANDS; s++) begin
                up_sum_reg[s]   <= '0;
                down_sum_reg[s] <= '0;
                est_reg[s]      <= EST_ONE;
                clip_reg[s]     <= 1'b0;
            end
        end else begin
            if (cfg_we) begin
                prior_reg <= cfg_prior;
            end
            if (cmd.item_apply) begin
                case (s_kind)
                    KIND_CLEAR: begin
                        for (int s = 0; s < NUM_STRANDS; s++) begin
                            up_sum_reg[s]   <= seed;
                            down_sum_reg[s] <= seed;
                            est_reg[s]      <= EST_ONE;
                            clip_reg[s]     <= 1'b0;
                        end
                    end
                    KIND_ACCUM: begin
                        if (in_ok && !s_outlier_hypothesis) begin
                            if (s_residual_positive) begin
                                up_sum_reg[s_strand_key] <= acc_sat;
                            end else begin
                                down_sum_reg[s_strand_key] <= acc_sat;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.est_write) begin
                est_reg[cmd.strand]  <= root_clip ? EST_MAX : r_reg[EST_W-1:0];
                clip_reg[cmd.strand] <= root_clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_apply) begin
            key_reg    <= s_strand_key;
            key_ok_reg <= in_ok;
            if (s_kind == KIND_CLEAR) begin
                out_est_reg <= in_ok ? EST_ONE : '0;
                out_sat_reg <= 1'b0;
            end else begin
                out_est_reg <= in_ok ? est_reg[s_strand_key] : '0;
                out_sat_reg <= in_ok ? clip_reg[s_strand_key] : 1'b0;
            end
        end
        if (cmd.load_upd_result) begin
            out_est_reg <= key_ok_reg ? est_reg[key_reg] : '0;
            out_sat_reg <= key_ok_reg ? clip_reg[key_reg] : 1'b0;
        end
        if (cmd.div_load) begin
            dvd_reg <= {rd_up, SUM_W'(0)};
            rem_reg <= '0;
            dsr_reg <= rd_down;
            dz_reg  <= (rd_down == '0);
        end
        if (cmd.div_step) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.sqrt_load) begin
            v_reg   <= dvd_reg;
            r_reg   <= '0;
            bit_reg <= QUO_W'(1) << (QUO_W - 2);
        end
        if (cmd.sqrt_step) begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign m_skew_est  = out_est_reg;
    assign m_saturated = out_sat_reg;

endmodule

[hw/rtl/weighted_sign_skew_estimator.sv]
// weighted_sign_skew_estimator: top level; joins wsse_ctrl and wsse_datapath.
// Depends on wsse_pkg, wsse_ctrl, wsse_datapath.
//
//  channel  ports                    direction  moves
//  s_       s_valid / s_ready        in         one item per transfer
//  m_       m_valid / m_ready        out        one result per item
//  cfg_     cfg_valid / cfg_ready    in         damping prior write
//
// Clear, accumulate and unused kinds: result registered next cycle.
// Update: the divider and square root, one bit per cycle each, are shared across
// strands and run for each strand in turn before the result is loaded.
// A strand with a zero down sum skips the divide and root.
// Reset is synchronous, active low; sums clear to zero, estimates to 1.0.
// A pending result only blocks new items when m_ready is low.
`timescale 1ns / 1ps

module weighted_sign_skew_estimator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsse_pkg::PRIOR_W-1:0]  cfg_damping_prior,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wsse_pkg::KIND_W-1:0]   s_kind,
    input  logic                          s_strand_key,
    input  logic [wsse_pkg::RESP_W-1:0]   s_responsibility,
    input  logic                          s_residual_positive,
    input  logic                          s_outlier_hypothesis,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wsse_pkg::EST_W-1:0]    m_skew_est,
    output logic                          m_saturated
);
    import wsse_pkg::*;

    wsse_cmd_t    cmd;
    wsse_status_t status;

    assign cfg_ready = 1'b1;

    wsse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    wsse_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_valid && cfg_ready),
        .cfg_prior            (cfg_damping_prior),
        .s_kind               (s_kind),
        .s_strand_key         (s_strand_key),
        .s_responsibility     (s_responsibility),
        .s_residual_positive  (s_residual_positive),
        .s_outlier_hypothesis (s_outlier_hypothesis),
        .cmd                  (cmd),
        .status               (status),
        .m_skew_est           (m_skew_est),
        .m_saturated          (m_saturated)
    );

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input ready while result register is blocked");

    a_update_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_UPDATE) |=> (!s_ready && !m_valid))
        else $error("update did not hold off the channels");

    a_short_item_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind != KIND_UPDATE) |=> m_valid)
        else $error("no result after a single-cycle item");

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_CLEAR)
        |=> (m_skew_est == EST_ONE && !m_saturated))
        else $error("clear did not return an estimate of one");

endmodule
